[rtl/lrcg_pkg.sv]
// ----------------------------------------------------------------------------
// lrcg_pkg
// Shared types and constants of the linear/radial colour gradient core.
// ----------------------------------------------------------------------------
package lrcg_pkg;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int POS_FIELD_W = 20;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int STEP_W      = 24;
    localparam int PERIOD_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int FRAC_BITS   = 12;
    localparam int ABS_W       = 16;   // |dx|, |dy| never exceed 65535
    localparam int RAD_W       = 34;   // dx^2 + dy^2, padded to even width
    localparam int ROOT_W      = 17;   // root never exceeds 92681
    localparam int REM_W       = 19;   // square root partial remainder
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    // Commands carried in tuser
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POS     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POINT   = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_START_COLOR = 3'd0;
    localparam logic [2:0] REG_END_COLOR   = 3'd1;
    localparam logic [2:0] REG_STEP_RED    = 3'd2;
    localparam logic [2:0] REG_STEP_GREEN  = 3'd3;
    localparam logic [2:0] REG_STEP_BLUE   = 3'd4;
    localparam logic [2:0] REG_PERIOD      = 3'd5;
    localparam logic [2:0] REG_MIRROR      = 3'd6;
    localparam logic [2:0] REG_ORIGIN_XY   = 3'd7;

    // Register reset values
    localparam logic [COLOR_W-1:0]  START_COLOR_RST = 24'hFF_FFFF;
    localparam logic [COLOR_W-1:0]  END_COLOR_RST   = 24'h00_0000;
    localparam logic [STEP_W-1:0]   STEP_RST        = 24'hFF_F010;  // -4080
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd256;
    localparam logic                MIRROR_RST      = 1'b1;
    localparam logic [31:0]         ORIGIN_RST      = 32'd0;

    // Main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RADIAL,
        ST_DIVIDE,
        ST_SCALE,
        ST_OUTPUT
    } lrcg_state_t;

    // Radial distance unit phases
    typedef enum logic [1:0] {
        RAD_IDLE,
        RAD_SQUARE,
        RAD_SUM,
        RAD_ROOT
    } rad_phase_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } rad_stat_t;

    // Control of one colour channel's serial multiplier and mapping
    typedef struct packed {
        logic load;      // clear the product accumulator
        logic shift;     // one multiplier bit step
        logic nbit;      // multiplier bit, LSB first
        logic bounded;   // period nonzero
        logic flip;      // mirrored odd half-period
        logic mirror;    // mirror register
    } chan_ctl_t;

endpackage

[rtl/lrcg_radial.sv]
// ----------------------------------------------------------------------------
// lrcg_radial
// Distance of a point from the origin: squares |dx| and |dy| bit-serially,
// adds them, then takes the floor square root two radicand bits a cycle.
// ----------------------------------------------------------------------------
module lrcg_radial
    import lrcg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ABS_W-1:0] abs_x,
    input  logic [ABS_W-1:0] abs_y,
    output rad_stat_t        stat
);

    localparam int CNT_W = 5;

    rad_phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ABS_W-1:0]  ax_reg, ay_reg;
    logic [ABS_W-1:0]  xhi_reg, xlo_reg, yhi_reg, ylo_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              done_reg;

    logic              sq_last, root_last;
    logic [ABS_W:0]    xsum, ysum;
    logic [REM_W+1:0]  shifted, trial;
    logic              ge;

    assign sq_last   = (cnt_reg == CNT_W'(ABS_W - 1));
    assign root_last = (cnt_reg == CNT_W'(ROOT_W - 1));

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            RAD_IDLE:   if (start) phase_next = RAD_SQUARE;
            RAD_SQUARE: if (sq_last) phase_next = RAD_SUM;
            RAD_SUM:    phase_next = RAD_ROOT;
            RAD_ROOT:   if (root_last) phase_next = RAD_IDLE;
            default:    phase_next = RAD_IDLE;
        endcase
    end

    // Shift-and-add square steps
    always_comb begin
        xsum = {1'b0, xhi_reg} + (xlo_reg[0] ? {1'b0, ax_reg} : '0);
        ysum = {1'b0, yhi_reg} + (ylo_reg[0] ? {1'b0, ay_reg} : '0);
    end

    // Restoring square root step
    always_comb begin
        shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = (shifted >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= RAD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= (phase_next != phase_reg) ? '0 : cnt_reg + 1'b1;
            done_reg  <= (phase_reg == RAD_ROOT) && root_last;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (phase_reg)
            RAD_IDLE: begin
                if (start) begin
                    ax_reg  <= abs_x;
                    ay_reg  <= abs_y;
                    xlo_reg <= abs_x;
                    ylo_reg <= abs_y;
                    xhi_reg <= '0;
                    yhi_reg <= '0;
                end
            end
            RAD_SQUARE: begin
                xhi_reg <= xsum[ABS_W:1];
                xlo_reg <= {xsum[0], xlo_reg[ABS_W-1:1]};
                yhi_reg <= ysum[ABS_W:1];
                ylo_reg <= {ysum[0], ylo_reg[ABS_W-1:1]};
            end
            RAD_SUM: begin
                rad_reg  <= RAD_W'({xhi_reg, xlo_reg}) + RAD_W'({yhi_reg, ylo_reg});
                rem_reg  <= '0;
                root_reg <= '0;
            end
            RAD_ROOT: begin
                rem_reg  <= ge ? REM_W'(shifted - trial) : shifted[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            default: ;
        endcase
    end

    assign stat.done = done_reg;
    assign stat.root = root_reg;

    // A result only follows a run of the root phase
    a_done_after_root: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(phase_reg) == RAD_ROOT)
        else $error("radial done without root phase");

    // Start is only honoured when idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == RAD_IDLE && start) |=> phase_reg == RAD_SQUARE)
        else $error("radial start lost");

    // Remainder stays within 2*root
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ({1'b0, rem_reg} <= {root_reg, 1'b0}))
        else $error("square root remainder out of range");

endmodule

[rtl/lrcg_chan.sv]
// ----------------------------------------------------------------------------
// lrcg_chan
// One colour channel: bit-serial |step| * n product, then the bounded or
// endless mapping of the Q12.12 delta onto an 8-bit component.
// ----------------------------------------------------------------------------
module lrcg_chan
    import lrcg_pkg::*;
#(
    parameter int PW = 20
) (
    input  logic              aclk,
    input  chan_ctl_t         ctl,
    input  logic [STEP_W-1:0] step,
    input  logic [BYTE_W-1:0] start_byte,
    input  logic [BYTE_W-1:0] end_byte,
    output logic [BYTE_W-1:0] colour
);

    localparam int PROD_W = STEP_W + PW;
    localparam int M_LO   = FRAC_BITS;
    localparam int M_HI   = FRAC_BITS + BYTE_W;   // bit 8 of delta

    logic [STEP_W-1:0] hi_reg;
    logic [PW-1:0]     lo_reg;

    logic [STEP_W-1:0] mag;
    logic [STEP_W:0]   sum;
    logic [PROD_W-1:0] prod;
    logic              neg, hi_nz, m_gt_s;
    logic [BYTE_W:0]   m9, s9, a9;
    logic [BYTE_W-1:0] d8, fwd, back, folded;

    // Magnitude of the signed step
    assign mag = step[STEP_W-1] ? STEP_W'(-step) : step;
    assign sum = {1'b0, hi_reg} + (ctl.nbit ? {1'b0, mag} : '0);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            hi_reg <= '0;
        end else if (ctl.shift) begin
            hi_reg <= sum[STEP_W:1];
            lo_reg <= {sum[0], lo_reg[PW-1:1]};
        end
    end

    // Colour mapping from the truncated delta
    always_comb begin
        prod   = {hi_reg, lo_reg};
        neg    = step[STEP_W-1];
        m9     = prod[M_HI:M_LO];
        hi_nz  = |prod[PROD_W-1:M_HI+1];
        s9     = {1'b0, start_byte};
        d8     = neg ? BYTE_W'(8'd0 - m9[BYTE_W-1:0]) : m9[BYTE_W-1:0];
        fwd    = BYTE_W'(start_byte + d8);
        back   = BYTE_W'(end_byte - d8);
        m_gt_s = hi_nz || (m9 > s9);
        if (!neg)
            a9 = s9 + m9;
        else if (m_gt_s)
            a9 = m9 - s9;
        else
            a9 = s9 - m9;
        // odd 256-band runs backwards
        folded = a9[BYTE_W] ? ~a9[BYTE_W-1:0] : a9[BYTE_W-1:0];
        if (ctl.bounded)
            colour = ctl.flip ? back : fwd;
        else
            colour = ctl.mirror ? folded : fwd;
    end

endmodule

[rtl/linear_radial_color_gradient_core.sv]
// ----------------------------------------------------------------------------
// linear_radial_color_gradient_core
// Gradient colour for a given position, the running sequence position or
// the distance of a point from a configured origin.
//
// Word flow, PW = max(POSITION_BITS, 17): bounded mode runs the PW-bit divide
//   and then the PW-bit scale, endless mode the scale only; point words first
//   take the squares and the 17-step square root.
// One word is in work at a time; the restart word is taken while idle and starts no work.
// The remainder divider and the channel multipliers take one bit a cycle.
// aresetn (synchronous) clears the counter and sequencer, loads defaults.
// ----------------------------------------------------------------------------
module linear_radial_color_gradient_core
    import lrcg_pkg::*;
#(
    parameter int POSITION_BITS = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // position[19:0], point_x, point_y
    input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red, green, blue
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int PW    = (POSITION_BITS > ROOT_W) ? POSITION_BITS : ROOT_W;
    localparam int CNT_W = $clog2(PW);

    // Configuration registers
    logic [COLOR_W-1:0]  start_color_reg, end_color_reg;
    logic [STEP_W-1:0]   step_red_reg, step_green_reg, step_blue_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                mirror_reg;
    logic [31:0]         origin_reg;

    // Sequencer and datapath
    lrcg_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [POSITION_BITS-1:0]  seq_reg;
    logic [PW-1:0]             n_reg;
    logic [PERIOD_W-1:0]       r_reg;
    logic                      qodd_reg;
    logic                      m_valid_reg;
    logic [OUT_TDATA_W-1:0]    m_data_reg;

    logic                      cfg_wr, accept, last, bounded, out_load, div_ge;
    logic [CMD_W-1:0]          cmd;
    logic [PW-1:0]             pos_field;
    logic signed [COORD_W:0]   dx, dy;
    logic [ABS_W-1:0]          abs_x, abs_y;
    logic [PERIOD_W:0]         div, rs;
    logic [PERIOD_W-1:0]       r_next;
    logic                      rad_start;
    rad_stat_t                 rad_stat;
    chan_ctl_t                 chan_ctl;
    logic [BYTE_W-1:0]         red, green, blue;

    assign cmd     = s_axis_tuser;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign last    = (cnt_reg == CNT_W'(PW - 1));
    assign bounded = (period_reg != '0);
    assign div     = {1'b0, period_reg} + 1'b1;

    // Position field masked to POSITION_BITS
    for (genvar gi = 0; gi < PW; gi++) begin : g_pos
        if (gi < POSITION_BITS && gi < POS_FIELD_W) begin : g_bit
            assign pos_field[gi] = s_axis_tdata[gi];
        end else begin : g_zero
            assign pos_field[gi] = 1'b0;
        end
    end

    // Offsets from the origin
    always_comb begin
        dx    = $signed({s_axis_tdata[35], s_axis_tdata[35:20]})
              - $signed({origin_reg[15], origin_reg[15:0]});
        dy    = $signed({s_axis_tdata[51], s_axis_tdata[51:36]})
              - $signed({origin_reg[31], origin_reg[31:16]});
        abs_x = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
        abs_y = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    end

    // Remainder divider step, position bits MSB first
    always_comb begin
        rs     = {r_reg, n_reg[PW-1]};
        div_ge = (rs >= div);
        r_next = div_ge ? PERIOD_W'(rs - div) : rs[PERIOD_W-1:0];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && cmd == CMD_POINT)
                    state_next = ST_RADIAL;
                else if (accept && (cmd == CMD_NEXT || cmd == CMD_POS))
                    state_next = bounded ? ST_DIVIDE : ST_SCALE;
            end
            ST_RADIAL: if (rad_stat.done) state_next = bounded ? ST_DIVIDE : ST_SCALE;
            ST_DIVIDE: if (last) state_next = ST_SCALE;
            ST_SCALE:  if (last) state_next = ST_OUTPUT;
            ST_OUTPUT: if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready    = (state_reg == ST_IDLE);
        rad_start        = accept && (cmd == CMD_POINT);
        out_load         = (state_reg == ST_OUTPUT) && (!m_valid_reg || m_axis_tready);
        chan_ctl.load    = (state_next == ST_SCALE) && (state_reg != ST_SCALE);
        chan_ctl.shift   = (state_reg == ST_SCALE);
        chan_ctl.nbit    = n_reg[0];
        chan_ctl.bounded = bounded;
        chan_ctl.flip    = mirror_reg && qodd_reg;
        chan_ctl.mirror  = mirror_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            seq_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? '0 : cnt_reg + 1'b1;
            if (accept && cmd == CMD_RESTART)
                seq_reg <= '0;
            else if (accept && cmd == CMD_NEXT)
                seq_reg <= seq_reg + 1'b1;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Position / remainder shift register
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                n_reg <= (cmd == CMD_NEXT) ? PW'(seq_reg) : pos_field;
                r_reg <= '0;
            end
            ST_RADIAL: begin
                n_reg <= PW'(rad_stat.root);
                r_reg <= '0;
            end
            ST_DIVIDE: begin
                n_reg    <= last ? PW'(r_next) : {n_reg[PW-2:0], 1'b0};
                r_reg    <= r_next;
                qodd_reg <= div_ge;
            end
            ST_SCALE: n_reg <= {1'b0, n_reg[PW-1:1]};
            default: ;
        endcase
        if (out_load)
            m_data_reg <= {blue, green, red};
    end

    // Register writes
    assign cfg_wr = psel && penable && pwrite && pready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_color_reg <= START_COLOR_RST;
            end_color_reg   <= END_COLOR_RST;
            step_red_reg    <= STEP_RST;
            step_green_reg  <= STEP_RST;
            step_blue_reg   <= STEP_RST;
            period_reg      <= PERIOD_RST;
            mirror_reg      <= MIRROR_RST;
            origin_reg      <= ORIGIN_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_START_COLOR: start_color_reg <= pwdata[COLOR_W-1:0];
                REG_END_COLOR:   end_color_reg   <= pwdata[COLOR_W-1:0];
                REG_STEP_RED:    step_red_reg    <= pwdata[STEP_W-1:0];
                REG_STEP_GREEN:  step_green_reg  <= pwdata[STEP_W-1:0];
                REG_STEP_BLUE:   step_blue_reg   <= pwdata[STEP_W-1:0];
                REG_PERIOD:      period_reg      <= pwdata[PERIOD_W-1:0];
                REG_MIRROR:      mirror_reg      <= pwdata[0];
                REG_ORIGIN_XY:   origin_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[4:2])
            REG_START_COLOR: prdata = CFG_DATA_W'(start_color_reg);
            REG_END_COLOR:   prdata = CFG_DATA_W'(end_color_reg);
            REG_STEP_RED:    prdata = CFG_DATA_W'(step_red_reg);
            REG_STEP_GREEN:  prdata = CFG_DATA_W'(step_green_reg);
            REG_STEP_BLUE:   prdata = CFG_DATA_W'(step_blue_reg);
            REG_PERIOD:      prdata = CFG_DATA_W'(period_reg);
            REG_MIRROR:      prdata = CFG_DATA_W'(mirror_reg);
            REG_ORIGIN_XY:   prdata = origin_reg;
            default:         prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Radial distance unit
    lrcg_radial u_radial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rad_start),
        .abs_x   (abs_x),
        .abs_y   (abs_y),
        .stat    (rad_stat)
    );

    // Colour channels
    lrcg_chan #(.PW(PW)) u_red (
        .aclk       (aclk),
        .ctl        (chan_ctl),
        .step       (step_red_reg),
        .start_byte (start_color_reg[7:0]),
        .end_byte   (end_color_reg[7:0]),
        .colour     (red)
    );

    lrcg_chan #(.PW(PW)) u_green (
        .aclk       (aclk),
        .ctl        (chan_ctl),
        .step       (step_green_reg),
        .start_byte (start_color_reg[15:8]),
        .end_byte   (end_color_reg[15:8]),
        .colour     (green)
    );

    lrcg_chan #(.PW(PW)) u_blue (
        .aclk       (aclk),
        .ctl        (chan_ctl),
        .step       (step_blue_reg),
        .start_byte (start_color_reg[23:16]),
        .end_byte   (end_color_reg[23:16]),
        .colour     (blue)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Restart word clears the sequence counter
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_RESTART) |=> seq_reg == '0)
        else $error("sequence counter not cleared");

    // Next-colour word advances the counter by one
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_NEXT) |=> seq_reg == POSITION_BITS'($past(seq_reg) + 1'b1))
        else $error("sequence counter did not advance");

    // Divider remainder stays below period + 1
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> ({1'b0, r_reg} < div))
        else $error("remainder out of range");

    // Radial result only arrives while waiting for it
    a_rad_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rad_stat.done |-> state_reg == ST_RADIAL)
        else $error("unexpected radial result");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUTPUT && m_valid_reg && !m_axis_tready)
            |=> (state_reg == ST_OUTPUT && m_data_reg == $past(m_data_reg)))
        else $error("pending result overwritten");

endmodule

[sim/linear_radial_color_gradient_core_test.sv]
// ----------------------------------------------------------------------------
// linear_radial_color_gradient_core_test
// Self-checking bench for the gradient colour core. A scoreboard predicts
// the colour of every accepted word other than a restart from the register
// settings it has seen written, and checks each result word in order. A short
// directed run at the reset settings is followed by several register phases
// of random words, with bursty input traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module linear_radial_color_gradient_core_test;
    import lrcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Counter width of the default build
    localparam int  SEQ_BITS    = 20;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  SETTLE      = 100;     // longest word latency, rounded up
    localparam int  PHASES      = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } colour_t;

    // ------------------------------------------------------------------------
    // Colour predictor and store of expected colours
    // ------------------------------------------------------------------------
    class gradient_board #(int SEQ_BITS = 20);
        localparam longint SEQ_MASK = (longint'(1) << SEQ_BITS) - 1;

        logic [COLOR_W-1:0]  start_rgb;
        logic [COLOR_W-1:0]  end_rgb;
        logic [STEP_W-1:0]   step_r;
        logic [STEP_W-1:0]   step_g;
        logic [STEP_W-1:0]   step_b;
        logic [PERIOD_W-1:0] period_len;
        logic                mirror_on;
        logic [31:0]         origin;
        longint              seq_pos;
        colour_t             expected_colours[$];
        int                  errors;

        function new();
            start_rgb  = START_COLOR_RST;
            end_rgb    = END_COLOR_RST;
            step_r     = STEP_RST;
            step_g     = STEP_RST;
            step_b     = STEP_RST;
            period_len = PERIOD_RST;
            mirror_on  = MIRROR_RST;
            origin     = ORIGIN_RST;
            seq_pos    = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_START_COLOR: start_rgb  = value[COLOR_W-1:0];
                REG_END_COLOR:   end_rgb    = value[COLOR_W-1:0];
                REG_STEP_RED:    step_r     = value[STEP_W-1:0];
                REG_STEP_GREEN:  step_g     = value[STEP_W-1:0];
                REG_STEP_BLUE:   step_b     = value[STEP_W-1:0];
                REG_PERIOD:      period_len = value[PERIOD_W-1:0];
                REG_MIRROR:      mirror_on  = value[0];
                REG_ORIGIN_XY:   origin     = value;
                default: ;
            endcase
        endfunction

        // step * n in Q12.12, truncated toward zero
        function longint scaled_delta(logic [STEP_W-1:0] step, longint n);
            longint prod;
            prod = longint'($signed(step)) * n;
            if (prod < 0)
                return -((-prod) >>> FRAC_BITS);
            return prod >>> FRAC_BITS;
        endfunction

        function logic [7:0] channel_value(logic [7:0] s, logic [7:0] e,
                                           logic [STEP_W-1:0] step, longint pos);
            longint span, rem, quo, v;
            if (period_len != 0) begin
                span = period_len;
                span = span + 1;
                rem  = pos % span;
                quo  = pos / span;
                // odd half-periods run back from the end colour
                if (mirror_on && quo[0])
                    return 8'(longint'(e) - scaled_delta(step, rem));
                return 8'(longint'(s) + scaled_delta(step, rem));
            end
            // endless: when mirrored, fold negative values and odd 256-bands back
            v = longint'(s) + scaled_delta(step, pos);
            if (mirror_on) begin
                if (v < 0)
                    v = -v;
                if (v[8])
                    v = 255 - v[7:0];
            end
            return v[7:0];
        endfunction

        function colour_t colour_at(longint pos);
            colour_t c;
            c.red   = channel_value(start_rgb[7:0],   end_rgb[7:0],   step_r, pos);
            c.green = channel_value(start_rgb[15:8],  end_rgb[15:8],  step_g, pos);
            c.blue  = channel_value(start_rgb[23:16], end_rgb[23:16], step_b, pos);
            return c;
        endfunction

        function longint root_floor(longint sq);
            longint r, trial;
            r = 0;
            for (int b = ROOT_W; b >= 0; b--) begin
                trial = r + (longint'(1) << b);
                if (trial * trial <= sq)
                    r = trial;
            end
            return r;
        endfunction

        // Accepted input word: update the counter, queue the colour it causes
        function void note_word(logic [CMD_W-1:0] cmd, logic [IN_TDATA_W-1:0] data);
            longint dx, dy;
            if (cmd == CMD_RESTART) begin
                seq_pos = 0;
            end else if (cmd == CMD_NEXT) begin
                expected_colours.push_back(colour_at(seq_pos & SEQ_MASK));
                seq_pos = (seq_pos + 1) & SEQ_MASK;
            end else if (cmd == CMD_POS) begin
                expected_colours.push_back(colour_at(longint'(data[19:0]) & SEQ_MASK));
            end else begin
                dx = longint'($signed(data[35:20])) - longint'($signed(origin[15:0]));
                dy = longint'($signed(data[51:36])) - longint'($signed(origin[31:16]));
                expected_colours.push_back(colour_at(root_floor(dx * dx + dy * dy)));
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            colour_t got, want;
            got = colour_t'(data);
            if (expected_colours.size() == 0) begin
                $error("result word %h with no colour expected", data);
                errors++;
                return;
            end
            want = expected_colours.pop_front();
            if (got.red != want.red) begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
            if (got.green != want.green) begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.blue != want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
        endfunction

        function int pending();
            return expected_colours.size();
        endfunction
    endclass

    typedef gradient_board #(SEQ_BITS) board_t;

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // position[19:0], point_x, point_y
    logic [CMD_W-1:0]       s_axis_tuser  = CMD_NEXT;   // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // red, green, blue
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr   = '0;
    logic [CFG_DATA_W-1:0]  pwdata  = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    board_t board = new();
    int cycle_count = 0;
    int ready_left  = 0;
    int stall_left  = 0;

    linear_radial_color_gradient_core #(
        .POSITION_BITS (SEQ_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: ready runs of random length, each followed by a stall
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                     : $urandom_range(1, 6);
            stall_left = $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
        end
    end

    // Both handshakes, sampled at the edge where they complete
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Leaves tvalid high; the caller decides whether a gap follows
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [19:0] pos,
                             logic [15:0] px, logic [15:0] py);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, py, px, pos};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_results();
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    // Idle the input, collect every result, then wait out the settle time
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait_results();
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus choices
    // ------------------------------------------------------------------------
    function automatic logic [19:0] pick_position();
        int unsigned span;
        span = board.period_len + 1;
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 300));
            2: return 20'(span * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 20'h0_0000;
                    1: return 20'hF_FFFF;
                    2: return 20'd255;
                    default: return 20'd256;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_coord(logic [15:0] centre);
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1: return centre + 16'($urandom_range(0, 600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'($urandom_range(0, 16384)) - 24'd8192;
            3: return 24'(4096 * $urandom_range(0, 8)) - 24'd16384;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic send_random_word(bit only_next);
        int unsigned roll;
        logic [CMD_W-1:0] cmd;
        roll = $urandom_range(0, 99);
        if (only_next || roll < 35)
            cmd = CMD_NEXT;
        else if (roll < 40)
            cmd = CMD_RESTART;
        else if (roll < 70)
            cmd = CMD_POS;
        else
            cmd = CMD_POINT;
        send_word(cmd, pick_position(), pick_coord(board.origin[15:0]),
                  pick_coord(board.origin[31:16]));
    endtask

    // Bursts of words; the first pause of each run waits for every result
    task automatic run_words(int count, bit only_next);
        int left, burst, roll;
        bit first;
        left  = count;
        first = 1'b1;
        while (left > 0) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                send_random_word(only_next);
                left--;
            end
            roll = $urandom_range(0, 19);
            if (first || roll == 0) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                wait_results();
                first = 1'b0;
            end else if (roll >= 7) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    endtask

    task automatic configure(int phase);
        logic [COLOR_W-1:0]  sc, ec;
        logic [STEP_W-1:0]   sr, sg, sb;
        logic [PERIOD_W-1:0] per;
        logic                mir;
        logic [31:0]         org;
        sc  = 24'($urandom);
        ec  = 24'($urandom);
        sr  = pick_step();
        sg  = pick_step();
        sb  = pick_step();
        per = pick_period();
        mir = 1'($urandom_range(0, 1));
        org = $urandom;
        case (phase)
            // endless, mirrored
            1: begin
                per = 16'd0;
                mir = 1'b1;
            end
            // endless, plain wrap, extreme steps and corner origin
            2: begin
                sc  = 24'h00_0000;
                ec  = 24'hFF_FFFF;
                sr  = 24'h7F_FFFF;
                sg  = 24'h80_0000;
                per = 16'd0;
                mir = 1'b0;
                org = 32'h8000_8000;
            end
            // shortest period
            3: begin
                sc  = 24'hFF_FFFF;
                ec  = 24'h00_0000;
                sr  = 24'h80_0000;
                sg  = 24'h7F_FFFF;
                sb  = 24'h00_0001;
                per = 16'd1;
                mir = 1'b1;
                org = 32'h7FFF_7FFF;
            end
            // longest period
            4: begin
                sb  = 24'h00_0000;
                per = 16'hFFFF;
                mir = 1'b1;
                org = 32'hFFFF_FFFF;
            end
            5: begin
                per = 16'd2;
                mir = 1'b0;
                org = 32'h0000_0000;
            end
            default: ;
        endcase
        write_reg(REG_START_COLOR, 32'(sc));
        write_reg(REG_END_COLOR,   32'(ec));
        write_reg(REG_STEP_RED,    32'(sr));
        write_reg(REG_STEP_GREEN,  32'(sg));
        write_reg(REG_STEP_BLUE,   32'(sb));
        write_reg(REG_PERIOD,      32'(per));
        write_reg(REG_MIRROR,      32'(mir));
        write_reg(REG_ORIGIN_XY,   org);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at the reset settings
        send_word(CMD_NEXT,    20'd0,       16'h0000, 16'h0000);
        send_word(CMD_NEXT,    20'd0,       16'h0000, 16'h0000);
        send_word(CMD_RESTART, 20'hF_FFFF,  16'hFFFF, 16'hFFFF);
        send_word(CMD_NEXT,    20'd0,       16'h0000, 16'h0000);
        send_word(CMD_POS,     20'd0,       16'h0000, 16'h0000);
        send_word(CMD_POS,     20'hF_FFFF,  16'h0000, 16'h0000);
        send_word(CMD_POS,     20'd255,     16'h0000, 16'h0000);
        send_word(CMD_POS,     20'd256,     16'h0000, 16'h0000);
        send_word(CMD_POS,     20'h5_5555,  16'h0000, 16'h0000);
        send_word(CMD_POS,     20'hA_AAAA,  16'h0000, 16'h0000);
        send_word(CMD_POINT,   20'd0,       16'h0000, 16'h0000);
        send_word(CMD_POINT,   20'd0,       16'd3,    16'd4);
        send_word(CMD_POINT,   20'd0,       16'hFFFF, 16'hFFFF);
        // distance 257: first odd half-period, mirrored
        send_word(CMD_POINT,   20'd0,       16'd257,  16'h0000);
        send_word(CMD_POINT,   20'd0,       16'h7FFF, 16'h7FFF);
        send_word(CMD_POINT,   20'd0,       16'h8000, 16'h8000);
        send_word(CMD_POINT,   20'd0,       16'h8000, 16'h7FFF);
        send_word(CMD_POINT,   20'd0,       16'h5555, 16'hAAAA);
        send_word(CMD_POINT,   20'd0,       16'hAAAA, 16'h5555);

        // Register phases of random words
        for (int phase = 1; phase <= PHASES; phase++) begin
            settle_idle();
            configure(phase);
            if (phase == 1) begin
                // long run of next-colour words from a cleared counter
                send_word(CMD_RESTART, 20'd0, 16'h0000, 16'h0000);
                run_words(300, 1'b1);
            end else begin
                run_words(210, 1'b0);
            end
        end

        settle_idle();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
